// ----- src/tmcle_pkg.sv -----
// ----------------------------------------------------------------------------
// tmcle_pkg
// Shared constants, command codes and item types of the text console.
// ----------------------------------------------------------------------------
package tmcle_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int MAX_LINE  = 255;
  localparam int TAB_WIDTH = 8;
  localparam int CELLS     = COLUMNS * ROWS;

  localparam int ADDR_W  = $clog2(CELLS);
  localparam int POS_W   = $clog2(CELLS + 1);
  localparam int ROW_W   = $clog2(ROWS + 1);
  localparam int COL_W   = $clog2(COLUMNS + 1);
  localparam int WORD_W  = 32;
  localparam int COLOR_W = 24;

  // row = (pos * DIV_MUL) >> DIV_SHIFT, then one correction step
  localparam int DIV_SHIFT = 20;
  localparam int DIV_MUL   = (1 << DIV_SHIFT) / COLUMNS;

  localparam logic [7:0]  CH_BS    = 8'h08;
  localparam logic [7:0]  CH_TAB   = 8'h09;
  localparam logic [7:0]  CH_LF    = 8'h0A;
  localparam logic [7:0]  CH_CR    = 8'h0D;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [23:0] WHITE        = 24'hFFFFFF;
  localparam logic [31:0] RESET_PERIOD = 32'd500000000;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_COLOR   = 1'b0,
    CFG_BLINK_PERIOD = 1'b1
  } cfg_idx_e;

  typedef enum logic [4:0] {
    CMD_PUT_CHAR    = 5'd0,
    CMD_CLEAR       = 5'd1,
    CMD_SCROLL      = 5'd2,
    CMD_EDIT_START  = 5'd3,
    CMD_TYPE        = 5'd4,
    CMD_RETURN      = 5'd5,
    CMD_DELETE      = 5'd6,
    CMD_BACKSPACE   = 5'd7,
    CMD_TAB         = 5'd8,
    CMD_HOME        = 5'd9,
    CMD_END         = 5'd10,
    CMD_INS_TOGGLE  = 5'd11,
    CMD_LEFT        = 5'd12,
    CMD_RIGHT       = 5'd13,
    CMD_TICK        = 5'd14,
    CMD_READ_CELL   = 5'd15,
    CMD_EDIT_FINISH = 5'd16
  } cmd_e;

  typedef struct packed {
    logic [4:0]  command;
    logic [7:0]  char_code;
    logic [4:0]  line_count;
    logic [31:0] elapsed;
    logic [10:0] cell_index;
  } in_item_t;

  typedef struct packed {
    logic [6:0]  cursor_column;
    logic [4:0]  cursor_row;
    logic        cursor_visible;
    logic        insert_mode;
    logic        edit_active;
    logic [7:0]  cell_char;
    logic [23:0] cell_color;
    logic        ignored;
  } out_item_t;

endpackage

// ----- src/tmcle_in_if.sv -----
// ----------------------------------------------------------------------------
// tmcle_in_if
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface tmcle_in_if;
  logic                valid;
  logic                ready;
  tmcle_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/tmcle_out_if.sv -----
// ----------------------------------------------------------------------------
// tmcle_out_if
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface tmcle_out_if;
  logic                 valid;
  logic                 ready;
  tmcle_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- src/tmcle_ram.sv -----
// ----------------------------------------------------------------------------
// tmcle_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tmcle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/text_mode_console_line_editor.sv -----
// ----------------------------------------------------------------------------
// text_mode_console_line_editor
// Character-cell console with cursor blink and a bounded line editor.
// Simple commands go from S_DISPATCH through S_FIN and the row/column
// division to S_OUT; cell moves run one cell per cycle through the cell RAM
// (scroll copies and blanks, clear blanks; insert type/delete/backspace shift
// the line; tabs repeat per space). One item is worked at a time; the next is
// accepted once the result is registered. After reset a pass blanks the RAM before any item.
// ----------------------------------------------------------------------------
module text_mode_console_line_editor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tmcle_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [tmcle_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  tmcle_in_if.sink                            in_i,
  tmcle_out_if.source                         out_o
);

  localparam int PW = tmcle_pkg::POS_W;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_DISPATCH, S_SCROLL, S_COPY, S_BLANK, S_LF, S_EMIT,
    S_EMIT_DIV, S_EMIT_TEST, S_TYPE, S_TYPE_PUT, S_TYPE_DIV, S_TYPE_TEST,
    S_TICK, S_READ, S_FIN, S_DIV_A, S_DIV_B, S_OUT
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic [PW-1:0] cur_q, cur_d, eb_q, eb_d, ee_q, ee_d;
  logic          edit_q, edit_d, ins_q, ins_d, phase_q, phase_d;
  logic [31:0]   timer_q, timer_d, period_q, period_d;
  logic [23:0]   color_q, color_d;
  logic [tmcle_pkg::ROW_W-1:0] row_q, row_d;
  logic [tmcle_pkg::COL_W-1:0] col_q, col_d;
  logic [PW-1:0] qest_q, qest_d;
  logic [4:0]    cmd_q, cmd_d, sn_q, sn_d;
  logic [7:0]    ch_q, ch_d;
  logic [31:0]   elapsed_q, elapsed_d;
  logic [10:0]   idx_q, idx_d;
  logic          ign_q, ign_d;
  logic [31:0]   rdc_q, rdc_d;
  logic [32:0]   sum_q, sum_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d, cnt_q, cnt_d, blank_q, blank_d;
  logic          pend_q, pend_d, down_q, down_d;
  logic          out_valid_q, out_valid_d;
  tmcle_pkg::out_item_t out_q, out_d;

  logic                          ram_we;
  logic [tmcle_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [tmcle_pkg::WORD_W-1:0]  ram_wdata, ram_rdata;

  tmcle_ram #(
    .WIDTH (tmcle_pkg::WORD_W),
    .DEPTH (tmcle_pkg::CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready  = (state_q == S_IDLE);
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_comb begin
    int          cur_i, eb_i, ee_i, nc, ne, t, r;
    logic [31:0] prod;
    logic [32:0] s;
    logic [7:0]  c;
    cur_i = int'(cur_q);
    eb_i  = int'(eb_q);
    ee_i  = int'(ee_q);
    nc    = 0;
    ne    = 0;
    t     = 0;
    r     = 0;
    prod  = '0;
    s     = '0;
    c     = (cmd_q == tmcle_pkg::CMD_TAB) ? tmcle_pkg::CH_SPACE : ch_q;

    state_d = state_q;  ret_d = ret_q;
    cur_d = cur_q;  eb_d = eb_q;  ee_d = ee_q;
    edit_d = edit_q;  ins_d = ins_q;  phase_d = phase_q;
    timer_d = timer_q;  period_d = period_q;  color_d = color_q;
    row_d = row_q;  col_d = col_q;  qest_d = qest_q;
    cmd_d = cmd_q;  sn_d = sn_q;  ch_d = ch_q;  elapsed_d = elapsed_q;  idx_d = idx_q;
    ign_d = ign_q;  rdc_d = rdc_q;  sum_d = sum_q;
    rd_ptr_d = rd_ptr_q;  wr_ptr_d = wr_ptr_q;  cnt_d = cnt_q;  blank_d = blank_q;
    pend_d = pend_q;  down_d = down_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_o.ready;

    ram_we    = 1'b0;
    ram_waddr = cur_q[tmcle_pkg::ADDR_W-1:0];
    ram_wdata = {c, color_q};
    ram_raddr = rd_ptr_q[tmcle_pkg::ADDR_W-1:0];

    if (cfg_we_i) begin
      unique case (tmcle_pkg::cfg_idx_e'(cfg_idx_i))
        tmcle_pkg::CFG_TEXT_COLOR:   color_d  = cfg_data_i[23:0];
        tmcle_pkg::CFG_BLINK_PERIOD: period_d = cfg_data_i;
      endcase
    end

    unique case (state_q)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = blank_q[tmcle_pkg::ADDR_W-1:0];
        ram_wdata = {tmcle_pkg::CH_SPACE, tmcle_pkg::WHITE};
        blank_d   = blank_q + PW'(1);
        if (int'(blank_q) == tmcle_pkg::CELLS - 1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d     = in_i.data.command;
          ch_d      = in_i.data.char_code;
          sn_d      = in_i.data.line_count;
          elapsed_d = in_i.data.elapsed;
          idx_d     = in_i.data.cell_index;
          ign_d     = 1'b0;
          rdc_d     = '0;
          state_d   = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        state_d = S_FIN;
        ret_d   = S_FIN;
        case (cmd_q)
          tmcle_pkg::CMD_PUT_CHAR: begin
            case (ch_q)
              tmcle_pkg::CH_BS: begin
                if (cur_i > 0) cur_d = cur_q - PW'(1);
                phase_d = 1'b1;
                timer_d = '0;
              end
              tmcle_pkg::CH_LF: begin
                ret_d   = S_LF;
                state_d = S_LF;
                if (int'(row_q) + 1 >= tmcle_pkg::ROWS) begin
                  sn_d    = 5'd1;
                  state_d = S_SCROLL;
                end
              end
              tmcle_pkg::CH_CR: begin
                cur_d   = PW'(int'(row_q) * tmcle_pkg::COLUMNS);
                phase_d = 1'b1;
                timer_d = '0;
              end
              default: state_d = S_EMIT;
            endcase
          end
          tmcle_pkg::CMD_CLEAR: begin
            sn_d    = 5'(tmcle_pkg::ROWS > 31 ? 31 : tmcle_pkg::ROWS);
            state_d = S_SCROLL;
          end
          tmcle_pkg::CMD_SCROLL: state_d = S_SCROLL;
          tmcle_pkg::CMD_EDIT_START: begin
            edit_d = 1'b1;
            eb_d   = cur_q;
            ee_d   = cur_q;
          end
          tmcle_pkg::CMD_TYPE, tmcle_pkg::CMD_TAB: begin
            if (!edit_q || ee_i - eb_i >= tmcle_pkg::MAX_LINE) begin
              ign_d = 1'b1;
            end else begin
              state_d = S_TYPE;
            end
          end
          tmcle_pkg::CMD_RETURN, tmcle_pkg::CMD_DELETE, tmcle_pkg::CMD_BACKSPACE,
          tmcle_pkg::CMD_HOME, tmcle_pkg::CMD_END, tmcle_pkg::CMD_INS_TOGGLE,
          tmcle_pkg::CMD_LEFT, tmcle_pkg::CMD_RIGHT: begin
            if (!edit_q) begin
              ign_d = 1'b1;
            end else begin
              case (cmd_q)
                tmcle_pkg::CMD_RETURN: begin
                  edit_d  = 1'b0;
                  cur_d   = ee_q;
                  phase_d = 1'b1;
                  timer_d = '0;
                end
                tmcle_pkg::CMD_DELETE: begin
                  if (cur_i < ee_i) begin
                    rd_ptr_d = cur_q + PW'(1);
                    wr_ptr_d = cur_q;
                    cnt_d    = ee_q - cur_q;
                    down_d   = 1'b0;
                    pend_d   = 1'b0;
                    blank_d  = PW'(tmcle_pkg::CELLS);
                    ee_d     = ee_q - PW'(1);
                    phase_d  = 1'b1;
                    timer_d  = '0;
                    state_d  = S_COPY;
                  end
                end
                tmcle_pkg::CMD_BACKSPACE: begin
                  if (cur_i > eb_i) begin
                    if (cur_i - 1 < ee_i) begin
                      rd_ptr_d = cur_q;
                      wr_ptr_d = cur_q - PW'(1);
                      cnt_d    = ee_q - cur_q + PW'(1);
                      down_d   = 1'b0;
                      pend_d   = 1'b0;
                      blank_d  = PW'(tmcle_pkg::CELLS);
                      ee_d     = ee_q - PW'(1);
                      state_d  = S_COPY;
                    end
                    cur_d   = cur_q - PW'(1);
                    phase_d = 1'b1;
                    timer_d = '0;
                  end
                end
                tmcle_pkg::CMD_HOME: begin
                  t       = int'(row_q) * tmcle_pkg::COLUMNS;
                  cur_d   = (t > eb_i) ? PW'(t) : eb_q;
                  phase_d = 1'b1;
                  timer_d = '0;
                end
                tmcle_pkg::CMD_END: begin
                  t       = (int'(row_q) + 1) * tmcle_pkg::COLUMNS - 1;
                  cur_d   = (t < ee_i) ? PW'(t) : ee_q;
                  phase_d = 1'b1;
                  timer_d = '0;
                end
                tmcle_pkg::CMD_INS_TOGGLE: begin
                  ins_d   = !ins_q;
                  phase_d = 1'b1;
                  timer_d = '0;
                end
                tmcle_pkg::CMD_LEFT: begin
                  if (cur_i > eb_i) begin
                    cur_d   = cur_q - PW'(1);
                    phase_d = 1'b1;
                    timer_d = '0;
                  end
                end
                default: begin
                  if (cur_i < ee_i) begin
                    cur_d   = cur_q + PW'(1);
                    phase_d = 1'b1;
                    timer_d = '0;
                  end
                end
              endcase
            end
          end
          tmcle_pkg::CMD_TICK: begin
            sum_d   = {1'b0, timer_q} + {1'b0, elapsed_q};
            state_d = S_TICK;
          end
          tmcle_pkg::CMD_READ_CELL: begin
            if (int'(idx_q) < tmcle_pkg::CELLS) begin
              ram_raddr = tmcle_pkg::ADDR_W'(idx_q);
              state_d   = S_READ;
            end
          end
          tmcle_pkg::CMD_EDIT_FINISH: edit_d = 1'b0;
          default: ;
        endcase
      end

      S_SCROLL: begin
        phase_d = 1'b1;
        timer_d = '0;
        pend_d  = 1'b0;
        down_d  = 1'b0;
        state_d = S_COPY;
        if (int'(sn_q) >= tmcle_pkg::ROWS) begin
          cur_d   = '0;
          cnt_d   = '0;
          blank_d = '0;
        end else begin
          t        = int'(sn_q) * tmcle_pkg::COLUMNS;
          rd_ptr_d = PW'(t);
          wr_ptr_d = '0;
          cnt_d    = PW'(tmcle_pkg::CELLS - t);
          blank_d  = PW'(tmcle_pkg::CELLS - t);
          cur_d    = (cur_i > t) ? PW'(cur_i - t) : '0;
          eb_d     = (eb_i > t) ? PW'(eb_i - t) : '0;
          ee_d     = (ee_i > t) ? PW'(ee_i - t) : '0;
        end
      end

      S_COPY: begin
        if (cnt_q != '0) begin
          rd_ptr_d = down_q ? rd_ptr_q - PW'(1) : rd_ptr_q + PW'(1);
          cnt_d    = cnt_q - PW'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_ptr_q[tmcle_pkg::ADDR_W-1:0];
          ram_wdata = ram_rdata;
          wr_ptr_d  = down_q ? wr_ptr_q - PW'(1) : wr_ptr_q + PW'(1);
        end
        if (cnt_q == '0 && !pend_q) begin
          state_d = (int'(blank_q) < tmcle_pkg::CELLS) ? S_BLANK : ret_q;
        end
      end

      S_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = blank_q[tmcle_pkg::ADDR_W-1:0];
        ram_wdata = {tmcle_pkg::CH_SPACE, color_q};
        blank_d   = blank_q + PW'(1);
        if (int'(blank_q) == tmcle_pkg::CELLS - 1) begin
          state_d = ret_q;
        end
      end

      S_LF: begin
        nc      = cur_i + tmcle_pkg::COLUMNS;
        cur_d   = (nc >= tmcle_pkg::CELLS) ? PW'(tmcle_pkg::CELLS - 1) : PW'(nc);
        phase_d = 1'b1;
        timer_d = '0;
        state_d = S_FIN;
      end

      S_EMIT: begin
        ram_we  = 1'b1;
        cur_d   = cur_q + PW'(1);
        phase_d = 1'b1;
        timer_d = '0;
        state_d = S_EMIT_DIV;
        if (cur_i + 1 >= tmcle_pkg::CELLS) begin
          sn_d    = 5'd1;
          ret_d   = S_EMIT_DIV;
          state_d = S_SCROLL;
        end
        ram_wdata = {(ch_q == tmcle_pkg::CH_TAB) ? tmcle_pkg::CH_SPACE : ch_q, color_q};
      end

      S_EMIT_DIV: begin
        ret_d   = S_EMIT_TEST;
        state_d = S_DIV_A;
      end

      S_EMIT_TEST: begin
        if (ch_q == tmcle_pkg::CH_TAB && (int'(col_q) % tmcle_pkg::TAB_WIDTH) != 0) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_FIN;
        end
      end

      S_TYPE: begin
        if (ins_q) begin
          rd_ptr_d = ee_q - PW'(1);
          wr_ptr_d = ee_q;
          cnt_d    = (ee_i > cur_i) ? ee_q - cur_q : '0;
          down_d   = 1'b1;
          pend_d   = 1'b0;
          blank_d  = PW'(tmcle_pkg::CELLS);
          ret_d    = S_TYPE_PUT;
          state_d  = S_COPY;
        end else begin
          state_d = S_TYPE_PUT;
        end
      end

      S_TYPE_PUT: begin
        ram_we  = 1'b1;
        nc      = cur_i + 1;
        ne      = ins_q ? ee_i + 1 : ((ee_i < nc) ? nc : ee_i);
        cur_d   = PW'(nc);
        ee_d    = PW'(ne);
        phase_d = 1'b1;
        timer_d = '0;
        state_d = S_TYPE_DIV;
        if (nc >= tmcle_pkg::CELLS || ne >= tmcle_pkg::CELLS) begin
          sn_d    = 5'd1;
          ret_d   = S_TYPE_DIV;
          state_d = S_SCROLL;
        end
      end

      S_TYPE_DIV: begin
        ret_d   = S_TYPE_TEST;
        state_d = S_DIV_A;
      end

      S_TYPE_TEST: begin
        if (cmd_q == tmcle_pkg::CMD_TAB && (int'(col_q) % tmcle_pkg::TAB_WIDTH) != 0
            && ee_i - eb_i < tmcle_pkg::MAX_LINE) begin
          state_d = S_TYPE;
        end else begin
          state_d = S_FIN;
        end
      end

      S_TICK: begin
        s = sum_q;
        if (s >= {1'b0, period_q}) begin
          phase_d = !phase_q;
          s       = s - {1'b0, period_q};
        end
        timer_d = s[32] ? 32'hFFFF_FFFF : s[31:0];
        state_d = S_FIN;
      end

      S_READ: begin
        rdc_d   = ram_rdata;
        state_d = S_FIN;
      end

      S_FIN: begin
        ret_d   = S_OUT;
        state_d = S_DIV_A;
      end

      S_DIV_A: begin
        prod    = 32'(cur_q) * 32'(tmcle_pkg::DIV_MUL);
        qest_d  = PW'(prod >> tmcle_pkg::DIV_SHIFT);
        state_d = S_DIV_B;
      end

      S_DIV_B: begin
        r = cur_i - int'(qest_q) * tmcle_pkg::COLUMNS;
        if (r >= tmcle_pkg::COLUMNS) begin
          row_d = tmcle_pkg::ROW_W'(int'(qest_q) + 1);
          col_d = tmcle_pkg::COL_W'(r - tmcle_pkg::COLUMNS);
        end else begin
          row_d = tmcle_pkg::ROW_W'(qest_q);
          col_d = tmcle_pkg::COL_W'(r);
        end
        state_d = ret_q;
      end

      S_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d          = 1'b1;
          out_d.cursor_column  = 7'(col_q);
          out_d.cursor_row     = 5'(row_q);
          out_d.cursor_visible = phase_q;
          out_d.insert_mode    = ins_q;
          out_d.edit_active    = edit_q;
          out_d.cell_char      = rdc_q[31:24];
          out_d.cell_color     = rdc_q[23:0];
          out_d.ignored        = ign_q;
          state_d              = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      ret_q       <= S_IDLE;
      cur_q       <= '0;
      eb_q        <= '0;
      ee_q        <= '0;
      edit_q      <= 1'b0;
      ins_q       <= 1'b1;
      phase_q     <= 1'b1;
      timer_q     <= '0;
      period_q    <= tmcle_pkg::RESET_PERIOD;
      color_q     <= tmcle_pkg::WHITE;
      row_q       <= '0;
      col_q       <= '0;
      cnt_q       <= '0;
      blank_q     <= '0;
      pend_q      <= 1'b0;
      down_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ret_q       <= ret_d;
      cur_q       <= cur_d;
      eb_q        <= eb_d;
      ee_q        <= ee_d;
      edit_q      <= edit_d;
      ins_q       <= ins_d;
      phase_q     <= phase_d;
      timer_q     <= timer_d;
      period_q    <= period_d;
      color_q     <= color_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cnt_q       <= cnt_d;
      blank_q     <= blank_d;
      pend_q      <= pend_d;
      down_q      <= down_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qest_q    <= qest_d;
    cmd_q     <= cmd_d;
    sn_q      <= sn_d;
    ch_q      <= ch_d;
    elapsed_q <= elapsed_d;
    idx_q     <= idx_d;
    ign_q     <= ign_d;
    rdc_q     <= rdc_d;
    sum_q     <= sum_d;
    rd_ptr_q  <= rd_ptr_d;
    wr_ptr_q  <= wr_ptr_d;
    out_q     <= out_d;
  end

endmodule
